// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the linked list engine; used by dll_ctrl.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DLL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("linked list engine: assertion failed");
`define DLL_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("linked list engine: forbidden condition seen");
`else
`define DLL_ASSERT(lbl, clk, rst, prop)
`define DLL_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- rtl/core/dll_pkg.sv -----
// Shared types and constants for the doubly linked list engine.
// Depends on nothing.
package dll_pkg;

  localparam int POOL_NODES_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int KIND_BITS      = 3;
  localparam int STATUS_BITS    = 3;
  localparam int ELEM_BITS      = 32;
  localparam int COUNT_BITS     = 7;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_DELETE     = 3'd2,
    KIND_WALK_FWD   = 3'd3,
    KIND_WALK_BWD   = 3'd4
  } dll_kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ELEMENT   = 3'd4,
    ST_EMPTY     = 3'd5
  } dll_status_t;

  // Field write enables of the node memory.
  typedef struct packed {
    logic value_en;
    logic next_en;
    logic prev_en;
  } dll_wmask_t;

  // Free slot stack requests.
  typedef struct packed {
    logic pop;
    logic push;
  } dll_stack_ctl_t;

endpackage

// ----- rtl/core/dll_node_mem.sv -----
// Node memory: value, forward link and backward link of every pool slot.
// Depends on dll_pkg. One write port with field enables, one registered read.
module dll_node_mem #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
  parameter int VALUE_BITS = dll_pkg::VALUE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic [$clog2(POOL_NODES)-1:0]           rd_addr,
  output logic [((VALUE_BITS < dll_pkg::ELEM_BITS) ?
                 VALUE_BITS : dll_pkg::ELEM_BITS)-1:0] rd_value,
  output logic [$clog2(POOL_NODES+1)-1:0]         rd_next,
  output logic [$clog2(POOL_NODES+1)-1:0]         rd_prev,
  input  logic                                    wr_en,
  input  logic [$clog2(POOL_NODES)-1:0]           wr_addr,
  input  dll_pkg::dll_wmask_t                     wr_mask,
  input  logic [((VALUE_BITS < dll_pkg::ELEM_BITS) ?
                 VALUE_BITS : dll_pkg::ELEM_BITS)-1:0] wr_value,
  input  logic [$clog2(POOL_NODES+1)-1:0]         wr_next,
  input  logic [$clog2(POOL_NODES+1)-1:0]         wr_prev
);

  localparam int SW = (VALUE_BITS < dll_pkg::ELEM_BITS) ? VALUE_BITS : dll_pkg::ELEM_BITS;
  localparam int LB = $clog2(POOL_NODES + 1);
  localparam int EW = SW + 2 * LB;

  logic [EW-1:0] mem [POOL_NODES];
  logic [EW-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_mask.value_en) mem[wr_addr][EW-1:2*LB] <= wr_value;
      if (wr_mask.next_en)  mem[wr_addr][2*LB-1:LB] <= wr_next;
      if (wr_mask.prev_en)  mem[wr_addr][LB-1:0]    <= wr_prev;
    end
    rd_word <= mem[rd_addr];
  end

  assign rd_value = rd_word[EW-1:2*LB];
  assign rd_next  = rd_word[2*LB-1:LB];
  assign rd_prev  = rd_word[LB-1:0];

endmodule

// ----- rtl/core/dll_free_stack.sv -----
// Stack of free pool slots, popped on insert and pushed on delete.
// Depends on dll_pkg. Positions below the low-water mark were never written;
// a pop there returns a slot number computed from the position, so the memory needs no clearing.
module dll_free_stack #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dll_pkg::dll_stack_ctl_t         ctl,
  input  logic [$clog2(POOL_NODES)-1:0]   push_slot,
  output logic [$clog2(POOL_NODES)-1:0]   pop_slot,
  output logic                            empty
);

  localparam int LB = $clog2(POOL_NODES + 1);
  localparam int IB = $clog2(POOL_NODES);

  logic [IB-1:0] mem [POOL_NODES];
  logic [LB-1:0] top;
  logic [LB-1:0] low_mark;
  logic [LB-1:0] top_dec;
  logic [IB-1:0] pop_pos;
  logic          fresh;
  logic [IB-1:0] rd_mem;
  logic [IB-1:0] rd_fresh;
  logic          rd_sel_fresh;

  assign top_dec = top - LB'(1);
  assign pop_pos = top_dec[IB-1:0];
  // The top can only sit at or above the low-water mark.
  assign fresh   = (top == low_mark);
  assign empty   = (top == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      top      <= LB'(POOL_NODES);
      low_mark <= LB'(POOL_NODES);
    end else if (ctl.pop) begin
      top <= top_dec;
      if (fresh) low_mark <= top_dec;
    end else if (ctl.push) begin
      top <= top + LB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.pop) mem[top[IB-1:0]] <= push_slot;
    rd_mem       <= mem[pop_pos];
    rd_fresh     <= IB'(POOL_NODES - 1) - pop_pos;
    rd_sel_fresh <= fresh;
  end

  assign pop_slot = rd_sel_fresh ? rd_fresh : rd_mem;

endmodule

// ----- rtl/core/dll_ctrl.sv -----
// Request sequencer of the linked list engine: pushes, delete search, walks.
// Depends on dll_pkg and assert_macros.svh; drives dll_node_mem and dll_free_stack.
`include "assert_macros.svh"
module dll_ctrl #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
  parameter int VALUE_BITS = dll_pkg::VALUE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [dll_pkg::KIND_BITS-1:0]           kind,
  input  logic signed [dll_pkg::ELEM_BITS-1:0]    value,
  output logic                                    strobe,
  output logic [dll_pkg::STATUS_BITS-1:0]         status,
  output logic signed [dll_pkg::ELEM_BITS-1:0]    element,
  output logic [dll_pkg::COUNT_BITS-1:0]          count,
  output logic                                    last,
  output logic [$clog2(POOL_NODES)-1:0]           mem_rd_addr,
  input  logic [((VALUE_BITS < dll_pkg::ELEM_BITS) ?
                 VALUE_BITS : dll_pkg::ELEM_BITS)-1:0] mem_rd_value,
  input  logic [$clog2(POOL_NODES+1)-1:0]         mem_rd_next,
  input  logic [$clog2(POOL_NODES+1)-1:0]         mem_rd_prev,
  output logic                                    mem_wr_en,
  output logic [$clog2(POOL_NODES)-1:0]           mem_wr_addr,
  output dll_pkg::dll_wmask_t                     mem_wr_mask,
  output logic [((VALUE_BITS < dll_pkg::ELEM_BITS) ?
                 VALUE_BITS : dll_pkg::ELEM_BITS)-1:0] mem_wr_value,
  output logic [$clog2(POOL_NODES+1)-1:0]         mem_wr_next,
  output logic [$clog2(POOL_NODES+1)-1:0]         mem_wr_prev,
  output dll_pkg::dll_stack_ctl_t                 stk_ctl,
  output logic [$clog2(POOL_NODES)-1:0]           stk_push_slot,
  input  logic [$clog2(POOL_NODES)-1:0]           stk_pop_slot,
  input  logic                                    stk_empty
);

  localparam int SW = (VALUE_BITS < dll_pkg::ELEM_BITS) ? VALUE_BITS : dll_pkg::ELEM_BITS;
  localparam int LB = $clog2(POOL_NODES + 1);
  localparam int IB = $clog2(POOL_NODES);
  localparam int CB = dll_pkg::COUNT_BITS;
  localparam int EB = dll_pkg::ELEM_BITS;
  localparam logic [LB-1:0] NIL      = LB'(POOL_NODES);
  localparam logic [IB-1:0] STEP_MAX = IB'(POOL_NODES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_SLOT,
    S_PUSH_LINK,
    S_DEL_CHECK,
    S_DEL_FIX,
    S_WALK
  } state_t;

  state_t             state;
  logic [LB-1:0]      head;
  logic [LB-1:0]      tail;
  logic [CB-1:0]      len;
  logic [LB-1:0]      cur;
  logic [LB-1:0]      link_r;
  logic [IB-1:0]      slot;
  logic [IB-1:0]      steps;
  logic [SW-1:0]      val_r;
  logic               dir_fwd;

  logic               accept;
  dll_pkg::dll_kind_t kind_c;
  logic [SW-1:0]      val_in;
  logic               head_ok;
  logic               tail_ok;
  logic               match;
  logic [LB-1:0]      walk_nx;
  logic               walk_last;
  logic               del_stop;

  function automatic logic link_ok(input logic [LB-1:0] l);
    return l < NIL;
  endfunction

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign kind_c    = dll_pkg::dll_kind_t'(kind);
  assign val_in    = value[SW-1:0];
  assign head_ok   = link_ok(head);
  assign tail_ok   = link_ok(tail);
  assign match     = (mem_rd_value == val_r);
  assign walk_nx   = dir_fwd ? mem_rd_next : mem_rd_prev;
  assign walk_last = !link_ok(walk_nx) || (steps == STEP_MAX);
  assign del_stop  = !link_ok(mem_rd_next) || (steps == STEP_MAX);

  // Memory and stack requests for the current step.
  always_comb begin
    mem_rd_addr   = cur[IB-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = cur[IB-1:0];
    mem_wr_mask   = '0;
    mem_wr_value  = val_r;
    mem_wr_next   = NIL;
    mem_wr_prev   = NIL;
    stk_ctl       = '0;
    stk_push_slot = cur[IB-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind_c)
            dll_pkg::KIND_PUSH_FRONT,
            dll_pkg::KIND_PUSH_BACK: stk_ctl.pop = !stk_empty;
            dll_pkg::KIND_DELETE,
            dll_pkg::KIND_WALK_FWD:  mem_rd_addr = head[IB-1:0];
            dll_pkg::KIND_WALK_BWD:  mem_rd_addr = tail[IB-1:0];
            default: ;
          endcase
        end
      end
      S_PUSH_SLOT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = stk_pop_slot;
        mem_wr_mask = '1;
        mem_wr_next = (head_ok && dir_fwd) ? head : NIL;
        mem_wr_prev = (head_ok && !dir_fwd) ? tail : NIL;
      end
      S_PUSH_LINK: begin
        // Hook the old end node onto the new one.
        mem_wr_en           = 1'b1;
        mem_wr_mask.prev_en = dir_fwd;
        mem_wr_mask.next_en = !dir_fwd;
        mem_wr_next         = LB'(slot);
        mem_wr_prev         = LB'(slot);
      end
      S_DEL_CHECK: begin
        if (match) begin
          stk_ctl.push        = 1'b1;
          mem_wr_en           = link_ok(mem_rd_prev);
          mem_wr_addr         = mem_rd_prev[IB-1:0];
          mem_wr_mask.next_en = 1'b1;
          mem_wr_next         = mem_rd_next;
        end else begin
          mem_rd_addr = mem_rd_next[IB-1:0];
        end
      end
      S_DEL_FIX: begin
        mem_wr_en           = link_ok(cur);
        mem_wr_mask.prev_en = 1'b1;
        mem_wr_prev         = link_r;
      end
      S_WALK: mem_rd_addr = walk_nx[IB-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      head   <= NIL;
      tail   <= NIL;
      len    <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            val_r   <= val_in;
            steps   <= '0;
            status  <= dll_pkg::ST_NOT_FOUND;
            element <= EB'(val_in);
            count   <= len;
            last    <= 1'b1;
            case (kind_c)
              dll_pkg::KIND_PUSH_FRONT,
              dll_pkg::KIND_PUSH_BACK: begin
                dir_fwd <= (kind_c == dll_pkg::KIND_PUSH_FRONT);
                if (stk_empty) begin
                  strobe <= 1'b1;
                  status <= dll_pkg::ST_FULL;
                end else begin
                  state <= S_PUSH_SLOT;
                end
              end
              dll_pkg::KIND_DELETE: begin
                cur <= head;
                if (!head_ok) strobe <= 1'b1;
                else state <= S_DEL_CHECK;
              end
              dll_pkg::KIND_WALK_FWD,
              dll_pkg::KIND_WALK_BWD: begin
                dir_fwd <= (kind_c == dll_pkg::KIND_WALK_FWD);
                cur     <= (kind_c == dll_pkg::KIND_WALK_FWD) ? head : tail;
                if (!head_ok) begin
                  strobe <= 1'b1;
                  status <= dll_pkg::ST_EMPTY;
                end else begin
                  state <= S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        S_PUSH_SLOT: begin
          slot    <= stk_pop_slot;
          len     <= len + CB'(1);
          status  <= dll_pkg::ST_INSERTED;
          element <= EB'(val_r);
          count   <= len + CB'(1);
          last    <= 1'b1;
          if (!head_ok) begin
            head   <= LB'(stk_pop_slot);
            tail   <= LB'(stk_pop_slot);
            strobe <= 1'b1;
            state  <= S_IDLE;
          end else if (dir_fwd) begin
            cur   <= head;
            head  <= LB'(stk_pop_slot);
            state <= S_PUSH_LINK;
          end else begin
            cur   <= tail;
            tail  <= LB'(stk_pop_slot);
            state <= S_PUSH_LINK;
          end
        end
        S_PUSH_LINK: begin
          strobe <= 1'b1;
          state  <= S_IDLE;
        end
        S_DEL_CHECK: begin
          element <= EB'(val_r);
          last    <= 1'b1;
          if (match) begin
            if (head == cur) head <= mem_rd_next;
            if (tail == cur) tail <= mem_rd_prev;
            len    <= len - CB'(1);
            cur    <= mem_rd_next;
            link_r <= mem_rd_prev;
            state  <= S_DEL_FIX;
          end else if (del_stop) begin
            strobe <= 1'b1;
            status <= dll_pkg::ST_NOT_FOUND;
            count  <= len;
            state  <= S_IDLE;
          end else begin
            cur   <= mem_rd_next;
            steps <= steps + IB'(1);
          end
        end
        S_DEL_FIX: begin
          strobe <= 1'b1;
          status <= dll_pkg::ST_DELETED;
          count  <= len;
          state  <= S_IDLE;
        end
        S_WALK: begin
          strobe  <= 1'b1;
          status  <= dll_pkg::ST_ELEMENT;
          element <= EB'(mem_rd_value);
          count   <= len;
          last    <= walk_last;
          if (walk_last) begin
            state <= S_IDLE;
          end else begin
            cur   <= walk_nx;
            steps <= steps + IB'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An empty list has no head, no tail and a zero length, all at once.
  `DLL_ASSERT(a_len_head, clk, rst, (len == '0) == !head_ok)
  `DLL_ASSERT_NEVER(a_head_tail, clk, rst, head_ok != tail_ok)
  // A walk word that is not the last is followed at once by the next one.
  `DLL_ASSERT(a_walk_run, clk, rst, strobe && !last |=> strobe)
  `DLL_ASSERT(a_full, clk, rst, accept && stk_empty && (kind_c == dll_pkg::KIND_PUSH_FRONT || kind_c == dll_pkg::KIND_PUSH_BACK) |=> strobe && status == dll_pkg::ST_FULL)

endmodule

// ----- rtl/core/doubly_linked_list_engine.sv -----
// Top level of the doubly linked list engine.
// Depends on dll_pkg, dll_node_mem, dll_free_stack and dll_ctrl.

// A request is taken when start is high and busy is low. Every result word
// appears for exactly one cycle with strobe high and cannot be held off; the
// final word of a request has last set. A push registers its one word in
// S_PUSH_SLOT when the list was empty and in S_PUSH_LINK otherwise.
// A delete visits one node per cycle and at most POOL_NODES nodes; a walk
// issues one word per cycle, one for each stored value. Both rates are set
// by the registered read of the node memory, which follows one link per
// cycle. A push on a full pool, a delete on an empty list and a walk of an
// empty list answer in the cycle after acceptance and leave busy low.
// Request kinds five to seven are dropped without a result.
module doubly_linked_list_engine #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
  parameter int VALUE_BITS = dll_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dll_pkg::KIND_BITS-1:0]        kind,
  input  logic signed [dll_pkg::ELEM_BITS-1:0] value,
  output logic                                 strobe,
  output logic [dll_pkg::STATUS_BITS-1:0]      status,
  output logic signed [dll_pkg::ELEM_BITS-1:0] element,
  output logic [dll_pkg::COUNT_BITS-1:0]       count,
  output logic                                 last
);

  localparam int SW = (VALUE_BITS < dll_pkg::ELEM_BITS) ? VALUE_BITS : dll_pkg::ELEM_BITS;
  localparam int LB = $clog2(POOL_NODES + 1);
  localparam int IB = $clog2(POOL_NODES);

  logic [IB-1:0]           mem_rd_addr;
  logic [SW-1:0]           mem_rd_value;
  logic [LB-1:0]           mem_rd_next;
  logic [LB-1:0]           mem_rd_prev;
  logic                    mem_wr_en;
  logic [IB-1:0]           mem_wr_addr;
  dll_pkg::dll_wmask_t     mem_wr_mask;
  logic [SW-1:0]           mem_wr_value;
  logic [LB-1:0]           mem_wr_next;
  logic [LB-1:0]           mem_wr_prev;
  dll_pkg::dll_stack_ctl_t stk_ctl;
  logic [IB-1:0]           stk_push_slot;
  logic [IB-1:0]           stk_pop_slot;
  logic                    stk_empty;

  dll_node_mem #(
    .POOL_NODES(POOL_NODES),
    .VALUE_BITS(VALUE_BITS)
  ) u_node_mem (
    .clk      (clk),
    .rd_addr  (mem_rd_addr),
    .rd_value (mem_rd_value),
    .rd_next  (mem_rd_next),
    .rd_prev  (mem_rd_prev),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_mask  (mem_wr_mask),
    .wr_value (mem_wr_value),
    .wr_next  (mem_wr_next),
    .wr_prev  (mem_wr_prev)
  );

  dll_free_stack #(
    .POOL_NODES(POOL_NODES)
  ) u_free_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (stk_ctl),
    .push_slot (stk_push_slot),
    .pop_slot  (stk_pop_slot),
    .empty     (stk_empty)
  );

  dll_ctrl #(
    .POOL_NODES(POOL_NODES),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .value         (value),
    .strobe        (strobe),
    .status        (status),
    .element       (element),
    .count         (count),
    .last          (last),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_value  (mem_rd_value),
    .mem_rd_next   (mem_rd_next),
    .mem_rd_prev   (mem_rd_prev),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_mask   (mem_wr_mask),
    .mem_wr_value  (mem_wr_value),
    .mem_wr_next   (mem_wr_next),
    .mem_wr_prev   (mem_wr_prev),
    .stk_ctl       (stk_ctl),
    .stk_push_slot (stk_push_slot),
    .stk_pop_slot  (stk_pop_slot),
    .stk_empty     (stk_empty)
  );

endmodule
